### rtl/core/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants for the convex polygon point test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpt_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 32;

    localparam int CFG_W      = 5;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 136;
    localparam int FIELD_W    = 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef struct packed {
        logic shift;
        logic wrap;
        logic wr_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/cpt_cell.sv
// ----------------------------------------------------------------------------
// cpt_cell
// One vertex slot of the rotating vertex ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpt_cell #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF
) (
    input  wire                          aclk,
    input  wire cpt_pkg::cell_ctrl_t     ctrl,
    input  wire signed [COORD_BITS-1:0]  wr_x,
    input  wire signed [COORD_BITS-1:0]  wr_y,
    input  wire signed [COORD_BITS-1:0]  nbr_x,
    input  wire signed [COORD_BITS-1:0]  nbr_y,
    input  wire signed [COORD_BITS-1:0]  head_x,
    input  wire signed [COORD_BITS-1:0]  head_y,
    output logic signed [COORD_BITS-1:0] vx,
    output logic signed [COORD_BITS-1:0] vy
);
    import cpt_pkg::*;

    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (ctrl.wr_en) begin
            x_next = wr_x;
            y_next = wr_y;
        end else if (ctrl.shift) begin
            x_next = ctrl.wrap ? head_x : nbr_x;
            y_next = ctrl.wrap ? head_y : nbr_y;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign vx = x_reg;
    assign vy = y_reg;

endmodule

`default_nettype wire

### rtl/core/cpt_edge.sv
// ----------------------------------------------------------------------------
// cpt_edge
// Three-stage edge test: differences, two products, signed compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpt_edge #(
    parameter int COORD_BITS = cpt_pkg::COORD_BITS_DEF
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         issue,
    input  wire signed [COORD_BITS-1:0] px,
    input  wire signed [COORD_BITS-1:0] py,
    input  wire signed [COORD_BITS-1:0] v0x,
    input  wire signed [COORD_BITS-1:0] v0y,
    input  wire signed [COORD_BITS-1:0] v1x,
    input  wire signed [COORD_BITS-1:0] v1y,
    output logic                        busy,
    output logic                        res_valid,
    output logic                        res_neg
);
    import cpt_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic v1_reg, v2_reg, v3_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, ex_reg, ey_reg;
    logic signed [PW-1:0] pa_reg, pb_reg;
    logic                 neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= DW'(px) - DW'(v0x);
        dy_reg  <= DW'(py) - DW'(v0y);
        ex_reg  <= DW'(v1x) - DW'(v0x);
        ey_reg  <= DW'(v1y) - DW'(v0y);
        pa_reg  <= PW'(dy_reg) * PW'(ex_reg);
        pb_reg  <= PW'(dx_reg) * PW'(ey_reg);
        neg_reg <= pa_reg < pb_reg;
    end

    assign busy      = v1_reg | v2_reg | v3_reg;
    assign res_valid = v3_reg;
    assign res_neg   = neg_reg;

endmodule

`default_nettype wire

### rtl/core/convex_polygon_point_test.sv
// ----------------------------------------------------------------------------
// convex_polygon_point_test
// Point-in-convex-polygon test with vertex bounding box.
// ----------------------------------------------------------------------------
// Vertices sit in a ring of cells, one vertex per cell. A write word (tuser 0)
// loads one cell and returns nothing. A test word (tuser 1) rotates the first
// N cells once around (N = vertex_count clamped to 3..MAX_VERTICES); each
// cycle the two head cells feed one edge to a shared pair of multipliers,
// and the result follows the ring rotation and the three-stage edge
// pipeline. The result sits in an output register, so the next word can be
// taken while it waits.
// vertex_count may only be written while no test is in flight.
`timescale 1ns / 1ps
`default_nettype none

module convex_polygon_point_test #(
    parameter int MAX_VERTICES = cpt_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = cpt_pkg::COORD_BITS_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [cpt_pkg::CFG_W-1:0]       cfg_data,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // vertex_index[3:0], coord_x[35:4], coord_y[67:36], zero pad
    input  wire [cpt_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[0]
    input  wire                            s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // inside_res[0], box_min_x[32:1], box_min_y[64:33],
    // box_max_x[96:65], box_max_y[128:97], zero pad
    output logic [cpt_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cpt_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] vcount_reg;
    logic [CMP_W-1:0] vc_ext;
    logic [CNT_W-1:0] n_eff;

    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic signed [COORD_BITS-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] minx_reg, miny_reg, maxx_reg, maxy_reg;
    logic                         inside_reg;
    logic                         m_tvalid_reg;
    logic [OUT_DATA_W-1:0]        m_tdata_reg;

    logic s_accept, run, out_load;
    logic edge_busy, edge_valid, edge_neg;

    logic signed [COORD_BITS-1:0] cx [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] cy [MAX_VERTICES];
    cell_ctrl_t                   ctrl [MAX_VERTICES];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid & s_tready;
    assign run       = (state_reg == ST_RUN);
    assign in_x      = COORD_BITS'(s_tdata[35:4]);
    assign in_y      = COORD_BITS'(s_tdata[67:36]);

    always_comb begin
        vc_ext = CMP_W'(vcount_reg);
        if (vc_ext < CMP_W'(3)) begin
            n_eff = CNT_W'(3);
        end else if (vc_ext > CMP_W'(MAX_VERTICES)) begin
            n_eff = CNT_W'(MAX_VERTICES);
        end else begin
            n_eff = CNT_W'(vc_ext);
        end
    end

    for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
        assign ctrl[k].wr_en = s_accept && (s_tuser == ACT_WRITE)
                               && (32'(s_tdata[3:0]) == k);
        assign ctrl[k].shift = run && (CNT_W'(k) < n_eff);
        assign ctrl[k].wrap  = (n_eff == CNT_W'(k + 1));

        cpt_cell #(
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl[k]),
            .wr_x   (in_x),
            .wr_y   (in_y),
            .nbr_x  (cx[(k + 1) % MAX_VERTICES]),
            .nbr_y  (cy[(k + 1) % MAX_VERTICES]),
            .head_x (cx[0]),
            .head_y (cy[0]),
            .vx     (cx[k]),
            .vy     (cy[k])
        );
    end

    cpt_edge #(
        .COORD_BITS(COORD_BITS)
    ) u_edge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (run),
        .px        (px_reg),
        .py        (py_reg),
        .v0x       (cx[0]),
        .v0y       (cy[0]),
        .v1x       (cx[1]),
        .v1y       (cy[1]),
        .busy      (edge_busy),
        .res_valid (edge_valid),
        .res_neg   (edge_neg)
    );

    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_accept && s_tuser == ACT_TEST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cnt_reg == n_eff - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!edge_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            vcount_reg   <= CFG_W'(4);
            m_tvalid_reg <= 1'b0;
            inside_reg   <= 1'b1;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                vcount_reg <= cfg_data;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_accept) begin
                inside_reg <= 1'b1;
            end else if (edge_valid && edge_neg) begin
                inside_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            px_reg   <= in_x;
            py_reg   <= in_y;
            minx_reg <= cx[0];
            maxx_reg <= cx[0];
            miny_reg <= cy[0];
            maxy_reg <= cy[0];
        end else if (run) begin
            if (cx[0] < minx_reg) minx_reg <= cx[0];
            if (cx[0] > maxx_reg) maxx_reg <= cx[0];
            if (cy[0] < miny_reg) miny_reg <= cy[0];
            if (cy[0] > maxy_reg) maxy_reg <= cy[0];
        end
        if (out_load) begin
            m_tdata_reg <= OUT_DATA_W'({
                FIELD_W'(maxy_reg),
                FIELD_W'(maxx_reg),
                FIELD_W'(miny_reg),
                FIELD_W'(minx_reg),
                inside_reg
            });
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### rtl/core/cpt_check.sv
// ----------------------------------------------------------------------------
// cpt_check
// Port-level checks for the convex polygon point test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpt_check (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            s_tuser,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [cpt_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import cpt_pkg::*;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_WRITE && !m_tvalid |=> !m_tvalid)
        else $error("vertex write produced a result word");

    a_test_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == ACT_TEST |=> !s_tready)
        else $error("input taken while a test was starting");

endmodule

bind convex_polygon_point_test cpt_check u_cpt_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### dv/cpt_point_checker.sv
// ----------------------------------------------------------------------------
// cpt_point_checker
// Watches the config, input and result channels of the convex polygon point
// test. Keeps its own vertex table and vertex_count, works out the inside
// flag and bounding box for every accepted test word and compares each
// result word with the oldest outstanding answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpt_point_checker (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire [cpt_pkg::CFG_W-1:0]         cfg_data,
    input  wire                              s_tvalid,
    input  wire                              s_tready,
    // vertex_index[3:0], coord_x[35:4], coord_y[67:36], zero pad
    input  wire [cpt_pkg::IN_DATA_W-1:0]     s_tdata,
    // action[0]
    input  wire                              s_tuser,
    input  wire                              m_tvalid,
    input  wire                              m_tready,
    // inside_res[0], box_min_x[32:1], box_min_y[64:33],
    // box_max_x[96:65], box_max_y[128:97], zero pad
    input  wire [cpt_pkg::OUT_DATA_W-1:0]    m_tdata,
    output int                               fail_count,
    output int                               pending
);

    localparam int MAXV = cpt_pkg::MAX_VERTICES_DEF;

    typedef struct packed {
        logic        in_poly;
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] max_x;
        logic [31:0] max_y;
    } hull_answer_t;

    logic signed [31:0] corner_x_q [MAXV];
    logic signed [31:0] corner_y_q [MAXV];
    logic [cpt_pkg::CFG_W-1:0] vertex_count_q;
    hull_answer_t hull_answer_q [$];

    function automatic hull_answer_t judge_point(input logic signed [31:0] px,
                                                 input logic signed [31:0] py);
        hull_answer_t ans;
        int n, i, j;
        logic signed [32:0] ex, ey, dx, dy;
        logic signed [65:0] lhs, rhs;
        logic signed [31:0] lo_x, lo_y, hi_x, hi_y;
        n = (vertex_count_q < 3) ? 3 :
            ((vertex_count_q > MAXV) ? MAXV : int'(vertex_count_q));
        ans.in_poly = 1'b1;
        lo_x = corner_x_q[0];
        hi_x = corner_x_q[0];
        lo_y = corner_y_q[0];
        hi_y = corner_y_q[0];
        for (i = 0; i < n; i++) begin
            j = (i + 1 < n) ? i + 1 : 0;
            ex = corner_x_q[j] - corner_x_q[i];
            ey = corner_y_q[j] - corner_y_q[i];
            dx = px - corner_x_q[i];
            dy = py - corner_y_q[i];
            lhs = dy * ex;
            rhs = dx * ey;
            if (lhs < rhs)
                ans.in_poly = 1'b0;
            if (corner_x_q[i] < lo_x) lo_x = corner_x_q[i];
            if (corner_x_q[i] > hi_x) hi_x = corner_x_q[i];
            if (corner_y_q[i] < lo_y) lo_y = corner_y_q[i];
            if (corner_y_q[i] > hi_y) hi_y = corner_y_q[i];
        end
        ans.min_x = lo_x;
        ans.min_y = lo_y;
        ans.max_x = hi_x;
        ans.max_y = hi_y;
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        hull_answer_t want, got;
        int k;
        if (!aresetn) begin
            vertex_count_q = 5'd4;
            hull_answer_q.delete();
            fail_count = 0;
            for (k = 0; k < MAXV; k++) begin
                corner_x_q[k] = '0;
                corner_y_q[k] = '0;
            end
        end else begin
            if (cfg_valid && cfg_ready)
                vertex_count_q = cfg_data;
            if (s_tvalid && s_tready) begin
                if (s_tuser == cpt_pkg::ACT_WRITE) begin
                    corner_x_q[s_tdata[3:0]] = s_tdata[35:4];
                    corner_y_q[s_tdata[3:0]] = s_tdata[67:36];
                end else begin
                    hull_answer_q.push_back(judge_point(s_tdata[35:4], s_tdata[67:36]));
                end
            end
            if (m_tvalid && m_tready) begin
                got.in_poly = m_tdata[0];
                got.min_x   = m_tdata[32:1];
                got.min_y   = m_tdata[64:33];
                got.max_x   = m_tdata[96:65];
                got.max_y   = m_tdata[128:97];
                if (hull_answer_q.size() == 0) begin
                    $error("result word arrived with no test outstanding");
                    fail_count++;
                end else begin
                    want = hull_answer_q.pop_front();
                    check_field("inside_res", 32'(want.in_poly), 32'(got.in_poly));
                    check_field("box_min_x", want.min_x, got.min_x);
                    check_field("box_min_y", want.min_y, got.min_y);
                    check_field("box_max_x", want.max_x, got.max_x);
                    check_field("box_max_y", want.max_y, got.max_y);
                end
            end
        end
        pending = hull_answer_q.size();
    end

endmodule

### dv/tb_convex_polygon_point_test.sv
// ----------------------------------------------------------------------------
// tb_convex_polygon_point_test
// Stimulus and verdict for the convex polygon point test. A short directed
// run with extreme coordinates, then phases that each set vertex_count,
// load a random, mostly convex polygon and fire test points at it (center, vertices,
// edge midpoints, near misses, anywhere), with random gaps and stalls on both
// channels, one long output stall and occasional stray vertex writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_convex_polygon_point_test;
    import cpt_pkg::*;

    localparam int ITEMS       = 550;
    localparam int SETTLE      = 30;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 300000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int words_sent  = 0;
    int tests_sent  = 0;
    int cfg_writes  = 0;
    bit calm        = 1'b0;
    bit burst       = 1'b0;
    bit stall_req   = 1'b0;

    logic [31:0] poly_x [MAX_VERTICES_DEF];
    logic [31:0] poly_y [MAX_VERTICES_DEF];
    int          poly_cx, poly_cy, poly_r;
    logic [4:0]  count_plan [8] = '{5'd0, 5'd31, 5'd16, 5'd2, 5'd17, 5'd3, 5'd5, 5'd1};

    convex_polygon_point_test u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cpt_point_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge that accepted the word
    task automatic push_word(input logic act, input logic [3:0] idx,
                             input logic [31:0] x, input logic [31:0] y);
        int gap;
        bit taken;
        gap = (calm || burst) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, y, x, idx};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        words_sent++;
        if (act == ACT_TEST)
            tests_sent++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
    endtask

    task automatic set_vertex_count(input logic [4:0] v);
        bit taken;
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic load_polygon(input int n);
        real step, ang;
        int kind, k;
        kind    = $urandom_range(0, 5);
        poly_cx = int'($urandom) >>> 2;
        poly_cy = int'($urandom) >>> 2;
        poly_r  = (kind == 0) ? $urandom_range(2, 64) : $urandom_range(256, 1 << 29);
        step    = 6.283185307179586 / n;
        for (k = 0; k < n; k++) begin
            ang = step * k + step * 0.4 * ($urandom_range(0, 1000) / 1000.0 - 0.5);
            if (kind == 5) begin
                // scrambled vertices, usually not convex
                poly_x[k] = $urandom;
                poly_y[k] = $urandom;
            end else begin
                poly_x[k] = poly_cx + $rtoi(poly_r * $cos(ang));
                poly_y[k] = poly_cy + $rtoi(poly_r * $sin(ang));
            end
            push_word(ACT_WRITE, k[3:0], poly_x[k], poly_y[k]);
        end
    endtask

    task automatic send_point(input int n);
        logic [31:0] x, y;
        int k, k1, r4;
        k  = $urandom_range(0, n - 1);
        k1 = (k + 1 < n) ? k + 1 : 0;
        r4 = poly_r / 4 + 1;
        case ($urandom_range(0, 5))
            0: begin
                x = $urandom;
                y = $urandom;
            end
            1: begin
                x = poly_cx + $urandom_range(0, 2 * r4) - r4;
                y = poly_cy + $urandom_range(0, 2 * r4) - r4;
            end
            2: begin
                x = poly_x[k];
                y = poly_y[k];
            end
            3: begin
                x = 32'((longint'($signed(poly_x[k])) + $signed(poly_x[k1])) >>> 1);
                y = 32'((longint'($signed(poly_y[k])) + $signed(poly_y[k1])) >>> 1);
            end
            4: begin
                x = poly_x[k] + $urandom_range(0, 2) - 1;
                y = poly_y[k] + $urandom_range(0, 2) - 1;
            end
            default: begin
                x = poly_cx + $urandom_range(0, 8 * r4) - 4 * r4;
                y = poly_cy + $urandom_range(0, 8 * r4) - 4 * r4;
            end
        endcase
        push_word(ACT_TEST, 4'($urandom), x, y);
    endtask

    // result side
    initial begin
        int hold;
        bit got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (stall_req) begin
                hold = LONG_HOLD;
                stall_req = 1'b0;
            end else begin
                hold = calm ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got = m_tvalid;
                @(posedge aclk);
            end while (!got);
        end
    end

    initial begin
        int phase, n, t, nt, k;
        logic [4:0] v;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-range square in slots 0..3, the rest random
        push_word(ACT_WRITE, 4'd0, 32'h8000_0000, 32'h8000_0000);
        push_word(ACT_WRITE, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(ACT_WRITE, 4'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_word(ACT_WRITE, 4'd3, 32'h8000_0000, 32'h7FFF_FFFF);
        for (k = 4; k < MAX_VERTICES_DEF; k++)
            push_word(ACT_WRITE, k[3:0], $urandom, $urandom);
        push_word(ACT_TEST, 4'd0, 32'h0000_0000, 32'h0000_0000);
        push_word(ACT_TEST, 4'd9, 32'h8000_0000, 32'h8000_0000);
        push_word(ACT_TEST, 4'd3, 32'h7FFF_FFFF, 32'h0000_0000);
        push_word(ACT_TEST, 4'hF, 32'h0000_0000, 32'h7FFF_FFFF);
        push_word(ACT_TEST, 4'd6, 32'h8000_0000, 32'h7FFF_FFFF);
        // triangle from the first three corners
        set_vertex_count(5'd3);
        push_word(ACT_TEST, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        push_word(ACT_TEST, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        push_word(ACT_TEST, 4'd2, 32'h0000_0000, 32'h0000_0000);

        phase = 0;
        while (words_sent < ITEMS) begin
            v = (phase < 8) ? count_plan[phase] : 5'($urandom_range(0, 31));
            set_vertex_count(v);
            n = (v < 3) ? 3 : ((v > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : int'(v));
            calm = ($urandom_range(0, 3) == 0);
            load_polygon(n);
            if (phase == 2) begin
                // output held off while tests keep coming
                stall_req = 1'b1;
                burst = 1'b1;
                repeat (12) send_point(n);
                burst = 1'b0;
            end
            nt = $urandom_range(15, 35);
            for (t = 0; t < nt; t++) begin
                if ($urandom_range(0, 19) == 0)
                    push_word(ACT_WRITE, 4'($urandom), $urandom, $urandom);
                else
                    send_point(n);
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        $display("Sent %0d words, %0d of them point tests, over %0d polygon phases",
                 words_sent, tests_sent, phase);
        $display("vertex_count written %0d times, clamped and extreme values included",
                 cfg_writes);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
